>>> rtl/bfsf_pkg.sv
// Shared constants, codes and control types for the bitmap free slot finder.
`timescale 1ns / 1ps

package bfsf_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int NUM_WORDS_DEF = 32;

    localparam int MODE_W     = 3;
    localparam int SLOT_W     = 10;
    localparam int RUN_W      = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 6;
    localparam int LEN_W      = RUN_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] WIU_RESET = CFG_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_USE = '0;

    localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIRST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RUN   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic loc_step;
        logic acc_exec;
        logic scan_step;
        logic out_load;
    } bfsf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic search_skip;
        logic loc_hit;
        logic loc_oor;
        logic scan_hit;
        logic scan_last;
    } bfsf_stat_t;

endpackage

>>> rtl/bfsf_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
`timescale 1ns / 1ps

interface bfsf_req_if import bfsf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot_index;
    logic [RUN_W-1:0]    run_length;

    modport source (output valid, output mode, output slot_index, output run_length,
                    input ready);
    modport sink (input valid, input mode, input slot_index, input run_length,
                  output ready);
endinterface

>>> rtl/bfsf_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps

interface bfsf_rsp_if import bfsf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  bit_value;
    logic [SLOT_W-1:0]     found_slot;

    modport source (output valid, output status, output bit_value, output found_slot,
                    input ready);
    modport sink (input valid, input status, input bit_value, input found_slot,
                  output ready);
endinterface

>>> rtl/bfsf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module bfsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/bfsf_datapath.sv
// Datapath: occupancy map RAM, word walker, per-word run evaluator and result registers.
`timescale 1ns / 1ps

module bfsf_datapath import bfsf_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_W-1:0]    words_in_use,
    input  logic [MODE_W-1:0]   in_mode,
    input  logic [SLOT_W-1:0]   in_slot,
    input  logic [RUN_W-1:0]    in_run,
    input  bfsf_cmd_t           cmd,
    output bfsf_stat_t          stat,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_bit,
    output logic [SLOT_W-1:0]   out_found
);

    localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W  = $clog2(NUM_WORDS + 1);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int BASE_W = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int LOC_W  = ((BASE_W + 1) > SLOT_W) ? (BASE_W + 1) : SLOT_W;
    localparam int SUM_W  = ((BASE_W > LEN_W) ? BASE_W : LEN_W) + 1;

    logic [CNT_W-1:0]     w_reg, w_next;
    logic [BASE_W-1:0]    base_reg;
    logic [RUN_W-1:0]     carry_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [RUN_W-1:0]     need_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic                 res_bit_reg;
    logic [SLOT_W-1:0]    res_found_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_bit_reg;
    logic [SLOT_W-1:0]    out_found_reg;

    logic [CMP_W-1:0]     wiu_ext;
    logic [CMP_W-1:0]     covered_wide;
    logic [CNT_W-1:0]     covered;
    logic [RUN_W-1:0]     in_need;
    logic                 in_access;
    logic                 in_search;

    logic [CNT_W-1:0]     w_plus;
    logic [BASE_W-1:0]    base_plus;
    logic [LOC_W-1:0]     base_hi;
    logic [LOC_W-1:0]     slot_off;
    logic                 loc_in_word;
    logic                 loc_oor;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [CNT_W-1:0]     raddr_sel;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] bit_mask;

    logic                 occ_any [WORD_BITS];
    logic [BIT_W-1:0]     occ_pos [WORD_BITS];
    logic [LEN_W-1:0]     run_len [WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;
    logic                 hit_any;
    logic [BIT_W-1:0]     hit_pos;
    logic [SUM_W-1:0]     start_sum;

    // Configured span, saturated to the physical map size.
    assign wiu_ext      = CMP_W'(words_in_use);
    assign covered_wide = (wiu_ext > CMP_W'(NUM_WORDS)) ? CMP_W'(NUM_WORDS) : wiu_ext;
    assign covered      = covered_wide[CNT_W-1:0];

    assign in_need   = (in_mode == MODE_FIRST) ? RUN_W'(1) : in_run;
    assign in_access = (in_mode == MODE_SET) || (in_mode == MODE_CLEAR)
                    || (in_mode == MODE_TEST);
    assign in_search = (in_mode == MODE_FIRST) || (in_mode == MODE_RUN);

    assign w_plus    = w_reg + CNT_W'(1);
    assign base_plus = base_reg + BASE_W'(WORD_BITS);

    // Locate the word holding the requested slot by walking word bases.
    assign base_hi     = LOC_W'(base_reg) + LOC_W'(WORD_BITS);
    assign slot_off    = LOC_W'(slot_reg) - LOC_W'(base_reg);
    assign loc_in_word = LOC_W'(slot_reg) < base_hi;
    assign loc_oor     = (w_reg == covered);

    assign raddr_sel = cmd.scan_step ? w_plus : w_reg;
    assign mem_raddr = raddr_sel[ADDR_W-1:0];
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign mem_we    = cmd.clear_step
                    || (cmd.acc_exec && ((mode_reg == MODE_SET) || (mode_reg == MODE_CLEAR)));

    always_comb
    begin
        if (cmd.clear_step)
        begin
            mem_wdata = '0;
        end
        else if (mode_reg == MODE_SET)
        begin
            mem_wdata = mem_rdata | bit_mask;
        end
        else
        begin
            mem_wdata = mem_rdata & ~bit_mask;
        end
    end

    bfsf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (w_reg[ADDR_W-1:0]),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Per bit: free-run length ending at that bit, carry from earlier words included.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            occ_any[b] = 1'b0;
            occ_pos[b] = '0;
            for (int j = 0; j <= b; j++)
            begin
                if (mem_rdata[j])
                begin
                    occ_any[b] = 1'b1;
                    occ_pos[b] = BIT_W'(j);
                end
            end
            if (mem_rdata[b])
            begin
                run_len[b] = '0;
            end
            else if (occ_any[b])
            begin
                run_len[b] = LEN_W'(b) - LEN_W'(occ_pos[b]);
            end
            else
            begin
                run_len[b] = LEN_W'(carry_reg) + LEN_W'(b + 1);
            end
            hit_vec[b] = !mem_rdata[b] && (run_len[b] >= LEN_W'(need_reg));
        end
        hit_any = 1'b0;
        hit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (hit_vec[b])
            begin
                hit_any = 1'b1;
                hit_pos = BIT_W'(b);
            end
        end
    end

    assign start_sum = SUM_W'(base_reg) + SUM_W'(hit_pos) + SUM_W'(1) - SUM_W'(need_reg);

    always_comb
    begin
        stat.clear_last  = (w_reg == CNT_W'(NUM_WORDS - 1));
        stat.search_skip = (in_need == '0) || (covered == '0);
        stat.loc_hit     = !loc_oor && loc_in_word;
        stat.loc_oor     = loc_oor;
        stat.scan_hit    = hit_any;
        stat.scan_last   = (w_plus == covered);
    end

    always_comb
    begin
        w_next = w_reg;
        if (cmd.capture)
        begin
            w_next = '0;
        end
        else if (cmd.clear_step)
        begin
            w_next = w_plus;
        end
        else if (cmd.loc_step && !loc_oor && !loc_in_word)
        begin
            w_next = w_plus;
        end
        else if (cmd.scan_step && !hit_any)
        begin
            w_next = w_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg      <= in_mode;
            slot_reg      <= in_slot;
            need_reg      <= in_need;
            base_reg      <= '0;
            carry_reg     <= '0;
            res_bit_reg   <= 1'b0;
            res_found_reg <= '0;
            if (in_access)
            begin
                res_status_reg <= STATUS_RANGE;
            end
            else if (in_search)
            begin
                res_status_reg <= STATUS_NONE;
            end
            else
            begin
                res_status_reg <= STATUS_OK;
            end
        end
        if (cmd.loc_step)
        begin
            if (!loc_oor && !loc_in_word)
            begin
                base_reg <= base_plus;
            end
            bit_reg <= slot_off[BIT_W-1:0];
        end
        if (cmd.acc_exec)
        begin
            res_status_reg <= STATUS_OK;
            if (mode_reg == MODE_TEST)
            begin
                res_bit_reg <= mem_rdata[bit_reg];
            end
        end
        if (cmd.scan_step)
        begin
            if (hit_any)
            begin
                res_status_reg <= STATUS_OK;
                res_found_reg  <= start_sum[SLOT_W-1:0];
            end
            else
            begin
                base_reg  <= base_plus;
                carry_reg <= run_len[WORD_BITS-1][RUN_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bit_reg    <= res_bit_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_bit    = out_bit_reg;
    assign out_found  = out_found_reg;

    a_scan_carry_short: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (carry_reg < need_reg))
        else $error("carried run already reached the wanted length");

    a_scan_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (w_reg < covered))
        else $error("scan outside the configured words");

    a_access_after_locate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_exec |-> $past(cmd.loc_step && stat.loc_hit))
        else $error("slot access without a located word");

endmodule

>>> rtl/bfsf_ctrl.sv
// Controller: sequences map clear, locate, access, scan and result hand-off.
`timescale 1ns / 1ps

module bfsf_ctrl import bfsf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bfsf_stat_t        stat,
    output bfsf_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOCATE = 7'b0000100,
        ST_ACCESS = 7'b0001000,
        ST_PRIME  = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_mode inside {MODE_SET, MODE_CLEAR, MODE_TEST})
                    begin
                        state_next = ST_LOCATE;
                    end
                    else if ((in_mode inside {MODE_FIRST, MODE_RUN}) && !stat.search_skip)
                    begin
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_LOCATE:
            begin
                cmd.loc_step = 1'b1;
                if (stat.loc_oor)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.loc_hit)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.acc_exec = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_PRIME:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit || stat.scan_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_word_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result word raised outside the result state");

    a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

endmodule

>>> rtl/bitmap_free_slot_finder.sv
// Top level: bitmap occupancy map with set, clear, test and first-fit run search.
// Set/clear/test: accept, locate by walking words up to the slot's word, then access and result;
// an out-of-range slot skips the access. Searches: accept, read prime, scan of the map words up to
// words_in_use, result. Requests are processed one at a time.
// After reset the map RAM is swept to zero, word by word, before a request is accepted.
// words_in_use resets to 32; configuration writes are taken at any time.
`timescale 1ns / 1ps

module bitmap_free_slot_finder import bfsf_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    bfsf_req_if.sink              req,
    bfsf_rsp_if.source            rsp
);

    logic [CFG_W-1:0] wiu_reg, wiu_next;
    logic             reg_sel;
    logic             cfg_wr;
    bfsf_cmd_t        cmd;
    bfsf_stat_t       stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_WORDS_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? APB_DATA_W'(wiu_reg) : '0;

    always_comb
    begin
        wiu_next = wiu_reg;
        if (cfg_wr)
        begin
            wiu_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg <= WIU_RESET;
        end
        else
        begin
            wiu_reg <= wiu_next;
        end
    end

    bfsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfsf_datapath #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .words_in_use (wiu_reg),
        .in_mode      (req.mode),
        .in_slot      (req.slot_index),
        .in_run       (req.run_length),
        .cmd          (cmd),
        .stat         (stat),
        .out_status   (rsp.status),
        .out_bit      (rsp.bit_value),
        .out_found    (rsp.found_slot)
    );

endmodule

>>> tb/tb_bitmap_free_slot_finder.sv
// Testbench for the bitmap free slot finder: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_bitmap_free_slot_finder;
    import bfsf_pkg::*;

    localparam int MAP_WORD_BITS   = WORD_BITS_DEF;
    localparam int MAP_WORDS       = NUM_WORDS_DEF;
    localparam int ITEM_TARGET     = 1350;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 10;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_MAX      = '1;
    localparam logic [RUN_W-1:0]  RUN_MAX       = RUN_W'(1024);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                bit_value;
        logic [SLOT_W-1:0]   found_slot;
    } slot_reply_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bfsf_req_if req_bus ();
    bfsf_rsp_if rsp_bus ();

    bitmap_free_slot_finder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_bus),
        .rsp     (rsp_bus)
    );

    // predictor state
    logic [MAP_WORD_BITS-1:0] occ_map [MAP_WORDS];
    logic [CFG_W-1:0]         map_words;

    slot_reply_t expected_replies [$];
    slot_reply_t got_reply;
    slot_reply_t want_reply;

    int item_count     = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int slot_cursor    = 0;
    bit req_gaps_on    = 1'b0;
    bit rsp_stalls_on  = 1'b0;
    bit rsp_hold_req   = 1'b0;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 80)
            return $urandom_range(3, 1);
        if (pick < 95)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic int covered_slots();
        int covered;
        covered = (map_words > MAP_WORDS) ? MAP_WORDS : int'(map_words);
        return covered * MAP_WORD_BITS;
    endfunction

    function automatic slot_reply_t predict_reply(input logic [MODE_W-1:0] m,
                                                  input logic [SLOT_W-1:0] s,
                                                  input logic [RUN_W-1:0] r);
        slot_reply_t rep;
        int span;
        int need;
        int run_start;
        int run_count;
        bit hit;
        rep       = '0;
        span      = covered_slots();
        run_start = 0;
        run_count = 0;
        hit       = 1'b0;
        case (m)
            MODE_SET, MODE_CLEAR, MODE_TEST:
            begin
                if (int'(s) >= span)
                    rep.status = STATUS_RANGE;
                else if (m == MODE_SET)
                    occ_map[s / MAP_WORD_BITS][s % MAP_WORD_BITS] = 1'b1;
                else if (m == MODE_CLEAR)
                    occ_map[s / MAP_WORD_BITS][s % MAP_WORD_BITS] = 1'b0;
                else
                    rep.bit_value = occ_map[s / MAP_WORD_BITS][s % MAP_WORD_BITS];
            end
            MODE_FIRST, MODE_RUN:
            begin
                need = (m == MODE_FIRST) ? 1 : int'(r);
                if (need != 0)
                begin
                    for (int i = 0; i < span && !hit; i++)
                    begin
                        if (occ_map[i / MAP_WORD_BITS][i % MAP_WORD_BITS])
                            run_count = 0;
                        else
                        begin
                            if (run_count == 0)
                                run_start = i;
                            run_count++;
                            if (run_count == need)
                                hit = 1'b1;
                        end
                    end
                end
                if (hit)
                    rep.found_slot = SLOT_W'(run_start);
                else
                    rep.status = STATUS_NONE;
            end
            default:
                rep = '0;
        endcase
        return rep;
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                                input logic [RUN_W-1:0] r);
        int gap;
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= m;
        req_bus.slot_index <= s;
        req_bus.run_length <= r;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        expected_replies.push_back(predict_reply(m, s, r));
        item_count++;
        gap = (req_gaps_on && $urandom_range(99, 0) < 30) ? gap_len() : 0;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_replies.size() != 0);
    endtask

    task automatic write_words_in_use(input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WORDS_IN_USE, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        map_words = value[CFG_W-1:0];
    endtask

    task automatic send_random_request(input int fill_pct);
        logic [MODE_W-1:0] m;
        logic [SLOT_W-1:0] s;
        logic [RUN_W-1:0]  r;
        int span;
        int pick;
        span = covered_slots();

        pick = $urandom_range(99, 0);
        if (pick < 52)
            m = ($urandom_range(99, 0) < fill_pct) ? MODE_SET : MODE_CLEAR;
        else if (pick < 65)
            m = MODE_TEST;
        else if (pick < 78)
            m = MODE_FIRST;
        else if (pick < 97)
            m = MODE_RUN;
        else
            m = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));

        // often walk a cursor so set/clear build contiguous blocks
        pick = $urandom_range(99, 0);
        if (span == 0 || pick < 8)
            s = SLOT_W'($urandom());
        else if (pick < 14)
            s = SLOT_W'(span - $urandom_range(1, 0));
        else if (pick < 17)
        begin
            slot_cursor = $urandom_range(span - 1, 0);
            s = SLOT_W'(slot_cursor);
        end
        else if (pick < 60)
        begin
            slot_cursor = (slot_cursor + 1) % span;
            s = SLOT_W'(slot_cursor);
        end
        else
            s = SLOT_W'($urandom_range(span - 1, 0));

        pick = $urandom_range(99, 0);
        if (pick < 4)
            r = '0;
        else if (pick < 45)
            r = RUN_W'($urandom_range(8, 1));
        else if (pick < 75)
            r = RUN_W'($urandom_range(48, 9));
        else if (pick < 90)
            r = RUN_W'($urandom_range(1024, 49));
        else if (pick < 96 && span > 0)
            r = RUN_W'(span - 1 + $urandom_range(2, 0));
        else
            r = RUN_MAX;

        send_request(m, s, r);
    endtask

    task automatic test_access_and_search();
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        send_request(MODE_FIRST, '0, '0);
        send_request(MODE_RUN, '0, RUN_MAX);
        send_request(MODE_RUN, SLOT_MAX, '0);
        send_request(MODE_SET, '0, '0);
        send_request(MODE_SET, SLOT_MAX, '0);
        send_request(MODE_TEST, SLOT_MAX, '1);
        send_request(MODE_TEST, SLOT_W'(1), '0);
        send_request(MODE_FIRST, '0, '0);
        send_request(MODE_RUN, '0, RUN_MAX - RUN_W'(2));
        send_request(MODE_CLEAR, '0, '0);
        send_request(MODE_TEST, '0, '0);
    endtask

    task automatic test_unused_modes();
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            send_request(MODE_W'(m), SLOT_MAX, RUN_MAX);
    endtask

    task automatic test_coverage_limits();
        wait_drained();
        write_words_in_use(32'd1);
        send_request(MODE_SET, SLOT_W'(31), '0);
        send_request(MODE_SET, SLOT_W'(32), '0);
        send_request(MODE_RUN, '0, RUN_W'(32));
        send_request(MODE_RUN, '0, RUN_W'(31));
        wait_drained();
        write_words_in_use(32'd0);
        send_request(MODE_TEST, '0, '0);
        send_request(MODE_FIRST, '0, '0);
        wait_drained();
        // above the map size: coverage saturates
        write_words_in_use(32'hFFFF_FFFF);
        send_request(MODE_TEST, SLOT_MAX, '0);
        send_request(MODE_RUN, '0, RUN_MAX - RUN_W'(1));
        wait_drained();
        write_words_in_use(32'd32);
    endtask

    task automatic test_backpressure();
        wait_drained();
        req_gaps_on  = 1'b0;
        rsp_hold_req = 1'b1;
        repeat (12) send_random_request(60);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int phase;
        int phase_items;
        int fill_pct;
        int pick;
        logic [APB_DATA_W-1:0] cfg;
        phase = 0;
        while (item_count < ITEM_TARGET)
        begin
            wait_drained();
            cfg  = $urandom();
            pick = $urandom_range(99, 0);
            if (phase == 0)
                cfg[CFG_W-1:0] = CFG_W'(1);
            else if (phase == 1)
                cfg[CFG_W-1:0] = CFG_W'(32);
            else if (pick < 35)
                cfg[CFG_W-1:0] = CFG_W'($urandom_range(4, 1));
            else if (pick < 60)
                cfg[CFG_W-1:0] = CFG_W'($urandom_range(16, 5));
            else if (pick < 92)
                cfg[CFG_W-1:0] = CFG_W'($urandom_range(32, 17));
            else if (pick < 96)
                cfg[CFG_W-1:0] = '0;
            else
                cfg[CFG_W-1:0] = CFG_W'($urandom_range(63, 33));
            write_words_in_use(cfg);

            pick          = $urandom_range(3, 0);
            req_gaps_on   = pick[0];
            rsp_stalls_on = pick[1];
            fill_pct      = $urandom_range(90, 15);
            slot_cursor   = (covered_slots() > 0) ? $urandom_range(covered_slots() - 1, 0) : 0;
            phase_items   = $urandom_range(160, 40);
            while (phase_items > 0 && item_count < ITEM_TARGET)
            begin
                send_random_request(fill_pct);
                phase_items--;
            end
            phase++;
        end
    endtask

    // result sink: random stalls, plus one long hold on request
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_req)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
                rsp_hold_req = 1'b0;
            end
            else if (rsp_stalls_on && $urandom_range(99, 0) < 20)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got_reply = {rsp_bus.status, rsp_bus.bit_value, rsp_bus.found_slot};
            if (expected_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: status %0d bit %0d slot %0d",
                             got_reply.status, got_reply.bit_value, got_reply.found_slot);
            end
            else
            begin
                want_reply = expected_replies.pop_front();
                if (got_reply.status !== want_reply.status
                    || got_reply.bit_value !== want_reply.bit_value
                    || got_reply.found_slot !== want_reply.found_slot)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected status %0d bit %0d slot %0d, got %0d %0d %0d",
                                 want_reply.status, want_reply.bit_value, want_reply.found_slot,
                                 got_reply.status, got_reply.bit_value, got_reply.found_slot);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_bus.valid      = 1'b0;
        req_bus.mode       = MODE_SET;
        req_bus.slot_index = '0;
        req_bus.run_length = '0;
        for (int i = 0; i < MAP_WORDS; i++)
            occ_map[i] = '0;
        map_words = WIU_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_access_and_search();
        test_unused_modes();
        test_coverage_limits();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> bitmap_free_slot_finder.f
rtl/bfsf_pkg.sv
rtl/bfsf_req_if.sv
rtl/bfsf_rsp_if.sv
rtl/bfsf_ram.sv
rtl/bfsf_datapath.sv
rtl/bfsf_ctrl.sv
rtl/bitmap_free_slot_finder.sv
tb/tb_bitmap_free_slot_finder.sv
